/* hw/rtl/kf3_pkg.sv */
package kf3_pkg;

   localparam int WORD_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int QUO_W      = WORD_W + FRAC_W;
   localparam int CNT_W      = $clog2(QUO_W);
   localparam int CFG_W      = WORD_W - 1;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = WORD_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 3 * WORD_W;
   localparam int RSP_USER_W = 1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam word_type WMAX    = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WMIN    = {1'b1, {(WORD_W-1){1'b0}}};
   localparam word_type ONE     = word_type'(1) <<< FRAC_W;
   localparam word_type HUNDRED = word_type'(100) <<< FRAC_W;

   localparam logic [CFG_W-1:0] DT_RESET = CFG_W'(6554);
   localparam logic [CFG_W-1:0] R_RESET  = CFG_W'(65536);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TIME_STEP = 3'd0,
      REG_MEAS_VAR  = 3'd1,
      REG_START_POS = 3'd2,
      REG_START_VEL = 3'd3,
      REG_START_ACC = 3'd4
   } reg_idx_type;

   typedef enum logic [REQ_USER_W-1:0] {
      OP_PREDICT = 2'd0,
      OP_CORRECT = 2'd1,
      OP_BOTH    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // saturating add or subtract; top bit is the saturation flag
   function automatic logic [WORD_W:0] sat_addsub(input word_type a, input word_type b,
                                                  input logic sub);
      logic signed [WORD_W:0] s;
      s = sub ? ((WORD_W+1)'(a) - (WORD_W+1)'(b)) : ((WORD_W+1)'(a) + (WORD_W+1)'(b));
      if (s[WORD_W] != s[WORD_W-1])
         return {1'b1, (s[WORD_W] ? WMIN : WMAX)};
      return {1'b0, s[WORD_W-1:0]};
   endfunction

   // exact product to word: drop fraction toward zero, then saturate
   function automatic logic [WORD_W:0] prod_scale(input prod_type p);
      prod_type                      biased;
      logic signed [PROD_W-FRAC_W-1:0] sh;
      biased = p + (p[PROD_W-1] ? prod_type'({FRAC_W{1'b1}}) : prod_type'(0));
      sh     = biased[PROD_W-1:FRAC_W];
      if (!((&sh[PROD_W-FRAC_W-1:WORD_W-1]) || !(|sh[PROD_W-FRAC_W-1:WORD_W-1])))
         return {1'b1, (sh[PROD_W-FRAC_W-1] ? WMIN : WMAX)};
      return {1'b0, sh[WORD_W-1:0]};
   endfunction

endpackage

/* hw/rtl/kalman_filter_const_accel_3state_top.sv */
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tdata: measurement; tuser: op
// rsp       out  rsp_tvalid/rsp_tready  tdata: position, velocity, acceleration; tuser: saturated
// csr       in   csr_we                 csr_addr, csr_wdata
//
// One request at a time through a single multiplier, saturating adder and a
// one-bit-a-cycle divider. Predict computes 63 products plus dt*dt/2, correct
// three divides plus 12 products, and both runs predict and then correct;
// an unused op answers the next cycle. The result waits in place until
// taken. Synchronous reset loads register defaults, the start estimate and
// 100 times identity covariance.
module kalman_filter_const_accel_3state_top
   import kf3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] measurement
   input  logic [REQ_USER_W-1:0] req_tuser,   // [1:0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] position, [63:32] velocity,
                                              // [95:64] acceleration
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] saturated
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [WORD_W-1:0]     csr_wdata
);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_HALF_MUL = 12'b000000000010,
      S_HALF_SH  = 12'b000000000100,
      S_MUL      = 12'b000000001000,
      S_SCALE    = 12'b000000010000,
      S_ACC      = 12'b000000100000,
      S_DEN      = 12'b000001000000,
      S_DIV_LD   = 12'b000010000000,
      S_DIV      = 12'b000100000000,
      S_DIV_FIN  = 12'b001000000000,
      S_INNOV    = 12'b010000000000,
      S_DONE     = 12'b100000000000
   } state_type;

   typedef enum logic [2:0] {
      PH_PX = 3'd0,   // x = A x
      PH_PT = 3'd1,   // T = A P
      PH_PP = 3'd2,   // P = T A'
      PH_CP = 3'd3,   // P -= K row0
      PH_CX = 3'd4    // x += K innov
   } phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   op_type      op_ff, op_in;
   word_type    meas_ff, meas_in;
   logic        sat_ff, sat_in;
   word_type    est_ff [3], est_in [3];
   word_type    cov_ff [9], cov_in [9];
   word_type    tmp_ff [9], tmp_in [9];
   word_type    nx_ff [3], nx_in [3];
   word_type    gain_ff [3], gain_in [3];
   word_type    row0_ff [3], row0_in [3];
   word_type    innov_ff, innov_in, half_ff, half_in, den_ff, den_in;
   word_type    acc_ff, acc_in, term_ff, term_in;
   prod_type    prod_ff, prod_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [CFG_W-1:0] dt_ff, dt_in, r_ff, r_in;
   word_type    pos0_ff, pos0_in, vel0_ff, vel0_in, acc0_ff, acc0_in;

   word_type    dt_word, r_word, cov_rd, est_rd, tmp_rd, opa, opb, add_a, add_b;
   logic [3:0]  cov_addr;
   logic        add_sub, add_sat, sc_sat, last_term, vec_phase, div_ge, div_over;
   word_type    add_res, sc_res, div_res;
   logic [WORD_W:0]   add_pack, sc_pack, rem_sh;
   logic [WORD_W-1:0] div_mag, num_mag;

   function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] c);
      return {2'b00, r} * 4'd3 + {2'b00, c};
   endfunction

   function automatic word_type a_elem(input logic [1:0] r, input logic [1:0] c,
                                       input word_type dt, input word_type half);
      case ({r, c})
         4'b0000, 4'b0101, 4'b1010: return ONE;
         4'b0001, 4'b0110:          return dt;
         4'b0010:                   return half;
         default:                   return '0;
      endcase
   endfunction

   assign dt_word = {1'b0, dt_ff};
   assign r_word  = {1'b0, r_ff};

   assign cov_addr = (state_ff == S_MUL)    ? idx(k_ff, j_ff) :
                     (state_ff == S_DIV_LD) ? idx(i_ff, 2'd0) : idx(i_ff, j_ff);
   assign cov_rd   = cov_ff[cov_addr];
   assign est_rd   = est_ff[(state_ff == S_MUL) ? k_ff : i_ff];
   assign tmp_rd   = tmp_ff[idx(i_ff, k_ff)];

   // multiplier operands
   always_comb begin
      opa = dt_word;
      opb = dt_word;
      if (state_ff != S_HALF_MUL) begin
         case (phase_ff)
            PH_PX: begin
               opa = a_elem(i_ff, k_ff, dt_word, half_ff);
               opb = est_rd;
            end
            PH_PT: begin
               opa = a_elem(i_ff, k_ff, dt_word, half_ff);
               opb = cov_rd;
            end
            PH_PP: begin
               opa = tmp_rd;
               opb = a_elem(j_ff, k_ff, dt_word, half_ff);
            end
            PH_CP: begin
               opa = gain_ff[i_ff];
               opb = row0_ff[j_ff];
            end
            PH_CX: begin
               opa = gain_ff[i_ff];
               opb = innov_ff;
            end
            default: begin
               opa = '0;
               opb = '0;
            end
         endcase
      end
   end

   assign prod_in = opa * opb;
   assign sc_pack = prod_scale(prod_ff);
   assign sc_sat  = sc_pack[WORD_W];
   assign sc_res  = sc_pack[WORD_W-1:0];

   // shared saturating adder
   always_comb begin
      add_a   = acc_ff;
      add_b   = term_ff;
      add_sub = 1'b0;
      case (state_ff)
         S_ACC: begin
            if (k_ff == 2'd0) begin
               case (phase_ff)
                  PH_CP:   add_a = cov_rd;
                  PH_CX:   add_a = est_rd;
                  default: add_a = '0;
               endcase
            end
            add_sub = (phase_ff == PH_CP);
         end
         S_DEN: begin
            add_a = r_word;
            add_b = cov_ff[0];
         end
         S_INNOV: begin
            add_a   = meas_ff;
            add_b   = est_ff[0];
            add_sub = 1'b1;
         end
         default: ;
      endcase
   end

   assign add_pack = sat_addsub(add_a, add_b, add_sub);
   assign add_sat  = add_pack[WORD_W];
   assign add_res  = add_pack[WORD_W-1:0];

   // divider step and finish
   assign num_mag = cov_rd[WORD_W-1] ? WORD_W'(-cov_rd) : WORD_W'(cov_rd);
   assign rem_sh  = {rem_ff, quo_ff[QUO_W-1]};
   assign div_ge  = rem_sh >= {1'b0, den_ff};
   assign div_over = neg_ff ? ((|quo_ff[QUO_W-1:WORD_W]) ||
                               (quo_ff[WORD_W-1] && (|quo_ff[WORD_W-2:0])))
                            : (|quo_ff[QUO_W-1:WORD_W-1]);
   assign div_mag = div_over ? (neg_ff ? WORD_W'(WMIN) : WORD_W'(WMAX))
                             : quo_ff[WORD_W-1:0];
   assign div_res = neg_ff ? word_type'(-div_mag) : word_type'(div_mag);

   assign vec_phase = (phase_ff == PH_PX) || (phase_ff == PH_CX);
   assign last_term = !((phase_ff == PH_PX) || (phase_ff == PH_PT) || (phase_ff == PH_PP))
                      || (k_ff == 2'd2);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      i_in = i_ff;  j_in = j_ff;  k_in = k_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;  meas_in = meas_ff;  sat_in = sat_ff;
      est_in = est_ff;  cov_in = cov_ff;  tmp_in = tmp_ff;  nx_in = nx_ff;
      gain_in = gain_ff;  row0_in = row0_ff;
      innov_in = innov_ff;  half_in = half_ff;  den_in = den_ff;
      acc_in = acc_ff;  term_in = term_ff;
      quo_in = quo_ff;  rem_in = rem_ff;  neg_in = neg_ff;
      dt_in = dt_ff;  r_in = r_ff;
      pos0_in = pos0_ff;  vel0_in = vel0_ff;  acc0_in = acc0_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = op_type'(req_tuser);
               meas_in = word_type'(req_tdata);
               sat_in  = 1'b0;
               i_in = 2'd0;  j_in = 2'd0;  k_in = 2'd0;
               case (op_type'(req_tuser))
                  OP_PREDICT, OP_BOTH: state_in = S_HALF_MUL;
                  OP_CORRECT:          state_in = S_DEN;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_HALF_MUL: state_in = S_HALF_SH;
         S_HALF_SH: begin
            half_in  = sc_res >>> 1;
            sat_in   = sat_ff | sc_sat;
            phase_in = PH_PX;
            state_in = S_MUL;
         end
         S_MUL: state_in = S_SCALE;
         S_SCALE: begin
            term_in  = sc_res;
            sat_in   = sat_ff | sc_sat;
            state_in = S_ACC;
         end
         S_ACC: begin
            sat_in   = sat_ff | add_sat;
            state_in = S_MUL;
            if (!last_term) begin
               acc_in = add_res;
               k_in   = k_ff + 2'd1;
            end else begin
               k_in = 2'd0;
               case (phase_ff)
                  PH_PX:          nx_in[i_ff] = add_res;
                  PH_PT:          tmp_in[idx(i_ff, j_ff)] = add_res;
                  PH_PP, PH_CP:   cov_in[idx(i_ff, j_ff)] = add_res;
                  PH_CX:          est_in[i_ff] = add_res;
                  default: ;
               endcase
               if (!vec_phase && j_ff != 2'd2) begin
                  j_in = j_ff + 2'd1;
               end else begin
                  j_in = 2'd0;
                  if (i_ff != 2'd2) begin
                     i_in = i_ff + 2'd1;
                  end else begin
                     i_in = 2'd0;
                     case (phase_ff)
                        PH_PX: begin
                           est_in[0] = nx_ff[0];
                           est_in[1] = nx_ff[1];
                           est_in[2] = add_res;
                           phase_in  = PH_PT;
                        end
                        PH_PT: phase_in = PH_PP;
                        PH_PP: state_in = (op_ff == OP_BOTH) ? S_DEN : S_DONE;
                        PH_CP: phase_in = PH_CX;
                        default: state_in = S_DONE;
                     endcase
                  end
               end
            end
         end
         S_DEN: begin
            den_in = add_res;
            sat_in = sat_ff | add_sat;
            if (add_res[WORD_W-1] || add_res == '0) begin
               // no usable innovation variance: skip the correction and flag saturation
               sat_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               row0_in[0] = cov_ff[0];
               row0_in[1] = cov_ff[1];
               row0_in[2] = cov_ff[2];
               i_in       = 2'd0;
               state_in   = S_DIV_LD;
            end
         end
         S_DIV_LD: begin
            neg_in   = cov_rd[WORD_W-1];
            quo_in   = {num_mag, {FRAC_W{1'b0}}};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = div_ge ? WORD_W'(rem_sh - {1'b0, den_ff}) : rem_sh[WORD_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1))
               state_in = S_DIV_FIN;
         end
         S_DIV_FIN: begin
            gain_in[i_ff] = div_res;
            sat_in        = sat_ff | div_over;
            if (i_ff != 2'd2) begin
               i_in     = i_ff + 2'd1;
               state_in = S_DIV_LD;
            end else begin
               i_in     = 2'd0;
               state_in = S_INNOV;
            end
         end
         S_INNOV: begin
            innov_in = add_res;
            sat_in   = sat_ff | add_sat;
            phase_in = PH_CP;
            i_in = 2'd0;  j_in = 2'd0;  k_in = 2'd0;
            state_in = S_MUL;
         end
         S_DONE: begin
            if (rsp_tready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // register writes reload the estimate and covariance
      if (csr_we && csr_addr <= REG_START_ACC) begin
         case (reg_idx_type'(csr_addr))
            REG_TIME_STEP: dt_in   = csr_wdata[CFG_W-1:0];
            REG_MEAS_VAR:  r_in    = csr_wdata[CFG_W-1:0];
            REG_START_POS: pos0_in = word_type'(csr_wdata);
            REG_START_VEL: vel0_in = word_type'(csr_wdata);
            REG_START_ACC: acc0_in = word_type'(csr_wdata);
            default: ;
         endcase
         est_in[0] = pos0_in;
         est_in[1] = vel0_in;
         est_in[2] = acc0_in;
         for (int n = 0; n < 9; n++)
            cov_in[n] = (n % 4 == 0) ? HUNDRED : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_PX;
         i_ff <= 2'd0;  j_ff <= 2'd0;  k_ff <= 2'd0;
         cnt_ff <= '0;
         sat_ff <= 1'b0;
         dt_ff  <= DT_RESET;
         r_ff   <= R_RESET;
         pos0_ff <= '0;  vel0_ff <= '0;  acc0_ff <= '0;
         for (int n = 0; n < 3; n++)
            est_ff[n] <= '0;
         for (int n = 0; n < 9; n++)
            cov_ff[n] <= (n % 4 == 0) ? HUNDRED : '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         i_ff <= i_in;  j_ff <= j_in;  k_ff <= k_in;
         cnt_ff <= cnt_in;
         sat_ff <= sat_in;
         dt_ff  <= dt_in;
         r_ff   <= r_in;
         pos0_ff <= pos0_in;  vel0_ff <= vel0_in;  acc0_ff <= acc0_in;
         est_ff <= est_in;
         cov_ff <= cov_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      meas_ff  <= meas_in;
      tmp_ff   <= tmp_in;
      nx_ff    <= nx_in;
      gain_ff  <= gain_in;
      row0_ff  <= row0_in;
      innov_ff <= innov_in;
      half_ff  <= half_in;
      den_ff   <= den_in;
      acc_ff   <= acc_in;
      term_ff  <= term_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata  = {est_ff[2], est_ff[1], est_ff[0]};
   assign rsp_tuser  = sat_ff;

endmodule

/* hw/rtl/kf3_checker.sv */
module kf3_checker
   import kf3_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one request in flight: nothing accepted while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request side ready while response pending");

   // an accepted request occupies the block for at least the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready straight after a request");

   // reset leaves no response behind
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind kalman_filter_const_accel_3state_top kf3_checker u_kf3_checker (.*);
